// File: hdl/hsv_to_rgb_converter_defines.svh
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define HSV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hsv_to_rgb_converter: assertion failed");
`define HSV_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hsv_to_rgb_converter: reset assertion failed");
`else
`define HSV_ASSERT(label, prop)
`define HSV_ASSERT_RST(label, prop)
`endif
`endif

// File: hdl/hsv2rgb_pkg.sv
// Shared widths, constants and sector codes for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int HUE_W  = 9;
  localparam int CH_W   = 8;
  localparam int FRAC_W = 6;
  localparam int PROD_W = 14;
  localparam int PN_W   = 2 * CH_W;
  localparam int QN_W   = CH_W + PROD_W;

  localparam int HUE_FULL    = 360;
  localparam int SECTOR_DEG  = 60;
  localparam int UNIT        = 255;
  localparam int UNIT_SECTOR = UNIT * SECTOR_DEG;

  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_t;

endpackage

// File: hdl/hsv2rgb_cdiv.sv
// Divide by a constant through an exact reciprocal multiply.
module hsv2rgb_cdiv #(
  parameter int DIVISOR = 255,
  parameter int IN_W    = 16,
  parameter int OUT_W   = 8
) (
  input  logic [IN_W-1:0]  dividend,
  output logic [OUT_W-1:0] quotient
);

  localparam int SHIFT_L = $clog2(DIVISOR);
  localparam int SHIFT_K = IN_W + SHIFT_L;
  localparam int M_W     = IN_W + 1;
  localparam int P_W     = IN_W + M_W;
  localparam longint unsigned MULT_FULL =
    ((longint'(1) << SHIFT_K) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam logic [M_W-1:0] MULT = M_W'(MULT_FULL);

  logic [P_W-1:0] prod;

  assign prod     = P_W'(dividend) * P_W'(MULT);
  assign quotient = OUT_W'(prod >> SHIFT_K);

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB converter.
//
// Input channel: in_valid/in_ready carry hue (0..360 degrees, 360 acts as 0,
// larger codes wrap by 360), sat and val (255 means 1.0).
// Output channel: out_valid/out_ready carry red, green and blue, one result
// item per input item, in input order.
// Pipeline: four register stages - hue wrap and sector split, saturation
// products, value products, then reciprocal division and channel select
// into the output register. Throughput is one item per cycle while
// out_ready stays high.
// Stall: when out_valid is high and out_ready low, every stage holds and
// in_ready drops; nothing is lost or repeated, and a new item is taken in
// the same cycle the output item leaves.
// Reset: synchronous rst clears all stage valid bits; in_ready is high
// right after reset. No clearing pass, no internal state beyond the pipe.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  sat,
  input  logic [CH_W-1:0]  val,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CH_W-1:0]  red,
  output logic [CH_W-1:0]  green,
  output logic [CH_W-1:0]  blue
);

`include "hsv_to_rgb_converter_defines.svh"

  logic advance;

  // stage 1
  logic              s1_valid;
  sector_t           s1_sector;
  logic [FRAC_W-1:0] s1_frac;
  logic [CH_W-1:0]   s1_sat;
  logic [CH_W-1:0]   s1_val;
  // stage 2
  logic              s2_valid;
  sector_t           s2_sector;
  logic [CH_W-1:0]   s2_pa;
  logic [PROD_W-1:0] s2_qa;
  logic [PROD_W-1:0] s2_ta;
  logic [CH_W-1:0]   s2_sat;
  logic [CH_W-1:0]   s2_val;
  // stage 3
  logic              s3_valid;
  sector_t           s3_sector;
  logic [PN_W-1:0]   s3_pn;
  logic [QN_W-1:0]   s3_qn;
  logic [QN_W-1:0]   s3_tn;
  logic [CH_W-1:0]   s3_sat;
  logic [CH_W-1:0]   s3_val;
  // output stage
  logic [CH_W-1:0]   out_sat;
  logic [CH_W-1:0]   out_val;

  logic [HUE_W-1:0]  hue_wrap;
  sector_t           sector_next;
  logic [FRAC_W-1:0] frac_next;
  logic [FRAC_W-1:0] frac_comp;
  logic [PROD_W-1:0] sf;
  logic [PROD_W-1:0] sg;
  logic [CH_W-1:0]   p_div;
  logic [CH_W-1:0]   q_div;
  logic [CH_W-1:0]   t_div;
  logic [CH_W-1:0]   red_next;
  logic [CH_W-1:0]   green_next;
  logic [CH_W-1:0]   blue_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // split hue into sector and offset within the sector
  always_comb begin
    hue_wrap = (hue >= HUE_W'(HUE_FULL)) ? hue - HUE_W'(HUE_FULL) : hue;
    if (hue_wrap >= HUE_W'(5 * SECTOR_DEG)) begin
      sector_next = SECT_MAGENTA;
      frac_next   = FRAC_W'(hue_wrap - HUE_W'(5 * SECTOR_DEG));
    end else if (hue_wrap >= HUE_W'(4 * SECTOR_DEG)) begin
      sector_next = SECT_BLUE;
      frac_next   = FRAC_W'(hue_wrap - HUE_W'(4 * SECTOR_DEG));
    end else if (hue_wrap >= HUE_W'(3 * SECTOR_DEG)) begin
      sector_next = SECT_CYAN;
      frac_next   = FRAC_W'(hue_wrap - HUE_W'(3 * SECTOR_DEG));
    end else if (hue_wrap >= HUE_W'(2 * SECTOR_DEG)) begin
      sector_next = SECT_GREEN;
      frac_next   = FRAC_W'(hue_wrap - HUE_W'(2 * SECTOR_DEG));
    end else if (hue_wrap >= HUE_W'(SECTOR_DEG)) begin
      sector_next = SECT_YELLOW;
      frac_next   = FRAC_W'(hue_wrap - HUE_W'(SECTOR_DEG));
    end else begin
      sector_next = SECT_RED;
      frac_next   = FRAC_W'(hue_wrap);
    end
  end

  assign frac_comp = FRAC_W'(SECTOR_DEG) - s1_frac;
  assign sf        = PROD_W'(s1_sat) * PROD_W'(s1_frac);
  assign sg        = PROD_W'(s1_sat) * PROD_W'(frac_comp);

  hsv2rgb_cdiv #(
    .DIVISOR (UNIT),
    .IN_W    (PN_W),
    .OUT_W   (CH_W)
  ) u_div_p (
    .dividend (s3_pn),
    .quotient (p_div)
  );

  hsv2rgb_cdiv #(
    .DIVISOR (UNIT_SECTOR),
    .IN_W    (QN_W),
    .OUT_W   (CH_W)
  ) u_div_q (
    .dividend (s3_qn),
    .quotient (q_div)
  );

  hsv2rgb_cdiv #(
    .DIVISOR (UNIT_SECTOR),
    .IN_W    (QN_W),
    .OUT_W   (CH_W)
  ) u_div_t (
    .dividend (s3_tn),
    .quotient (t_div)
  );

  // pick channels by sector; all channels are zero when val is zero
  always_comb begin
    if (s3_val == '0) begin
      red_next   = '0;
      green_next = '0;
      blue_next  = '0;
    end else begin
      case (s3_sector)
        SECT_RED: begin
          red_next = s3_val; green_next = t_div;  blue_next = p_div;
        end
        SECT_YELLOW: begin
          red_next = q_div;  green_next = s3_val; blue_next = p_div;
        end
        SECT_GREEN: begin
          red_next = p_div;  green_next = s3_val; blue_next = t_div;
        end
        SECT_CYAN: begin
          red_next = p_div;  green_next = q_div;  blue_next = s3_val;
        end
        SECT_BLUE: begin
          red_next = t_div;  green_next = p_div;  blue_next = s3_val;
        end
        default: begin
          red_next = s3_val; green_next = p_div;  blue_next = q_div;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sector <= sector_next;
      s1_frac   <= frac_next;
      s1_sat    <= sat;
      s1_val    <= val;

      s2_sector <= s1_sector;
      s2_pa     <= CH_W'(UNIT) - s1_sat;
      s2_qa     <= PROD_W'(UNIT_SECTOR) - sf;
      s2_ta     <= PROD_W'(UNIT_SECTOR) - sg;
      s2_sat    <= s1_sat;
      s2_val    <= s1_val;

      s3_sector <= s2_sector;
      s3_pn     <= PN_W'(s2_val) * PN_W'(s2_pa);
      s3_qn     <= QN_W'(s2_val) * QN_W'(s2_qa);
      s3_tn     <= QN_W'(s2_val) * QN_W'(s2_ta);
      s3_sat    <= s2_sat;
      s3_val    <= s2_val;

      red       <= red_next;
      green     <= green_next;
      blue      <= blue_next;
      out_sat   <= s3_sat;
      out_val   <= s3_val;
    end
  end

  `HSV_ASSERT_RST(a_reset_empty, rst |=> !out_valid)
  `HSV_ASSERT(a_stall_blocks_input, (out_valid && !out_ready) |-> !in_ready)
  `HSV_ASSERT(a_accept_enters, (in_valid && in_ready) |=> s1_valid)
  `HSV_ASSERT(a_black, (out_valid && out_val == '0) |-> (red == '0 && green == '0 && blue == '0))
  `HSV_ASSERT(a_gray, (out_valid && out_sat == '0) |-> (red == out_val && green == out_val && blue == out_val))

endmodule
